/* design/hkse_pkg.sv */
// ----------------------------------------------------------------------------
// hkse_pkg
// Shared types, constants and usage lookup for the HID keyboard report to
// Set1 scancode event translator.
// ----------------------------------------------------------------------------
package hkse_pkg;

	// Report slots carried by one input item
	localparam int MAX_SLOTS = 6;

	// Usage map bounds and special usages
	localparam int         MAP_SIZE    = 102;
	localparam logic [7:0] USAGE_FIRST = 8'h04;
	localparam logic [7:0] USAGE_PRTSC = 8'h46;
	localparam logic [7:0] USAGE_PAUSE = 8'h48;
	localparam logic [7:0] VK_PRTSC    = 8'h2C;
	localparam logic [7:0] VK_BREAK    = 8'h13;

	// Command codes
	localparam logic CMD_REPORT  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result item kinds and completion status
	localparam logic KIND_KEY   = 1'b0;
	localparam logic KIND_DONE  = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// Modifier bit to Set1 make code; E0 on right ctrl/alt and both GUI keys
	localparam logic [7:0] MOD_CODE [8] = '{
		8'h1D, 8'h2A, 8'h38, 8'h5B, 8'h1D, 8'h36, 8'h38, 8'h5C
	};
	localparam logic [7:0] MOD_EXT = 8'hD8;

	// Usage id to Set1 make code
	localparam logic [7:0] USAGE_CODE [MAP_SIZE] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
		8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
		8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
		8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
		8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
		8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
		8'h1B, 8'h2B, 8'h56, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
		8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
		8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00, 8'h46,
		8'h00, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D,
		8'h4B, 8'h50, 8'h48, 8'h45, 8'h35, 8'h37, 8'h4A, 8'h4E,
		8'h1C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47,
		8'h48, 8'h49, 8'h52, 8'h53, 8'h56, 8'h5D
	};

	// Input item
	typedef struct packed {
		logic       cmd;
		logic [7:0] modifiers;
		logic [7:0] reserved_byte;
		logic [7:0] key_0;
		logic [7:0] key_1;
		logic [7:0] key_2;
		logic [7:0] key_3;
		logic [7:0] key_4;
		logic [7:0] key_5;
	} rpt_item_t;

	// Result item
	typedef struct packed {
		logic       kind;
		logic [7:0] scancode;
		logic       extended;
		logic       use_vk;
		logic [7:0] vk_code;
		logic       pressed;
		logic       status;
		logic       last;
	} evt_item_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EMIT
	} state_t;

	// Usage produces an event at all
	function automatic logic usage_mapped(input logic [7:0] u);
		return (u >= USAGE_FIRST) && (u < MAP_SIZE);
	endfunction

	// Key event for a mapped usage
	function automatic evt_item_t usage_event(input logic [7:0] u, input logic down);
		evt_item_t e;
		e         = '0;
		e.kind    = KIND_KEY;
		e.pressed = down;
		if (u == USAGE_PRTSC) begin
			e.use_vk  = 1'b1;
			e.vk_code = VK_PRTSC;
		end else if (u == USAGE_PAUSE) begin
			e.use_vk  = 1'b1;
			e.vk_code = VK_BREAK;
		end else if (u < MAP_SIZE) begin
			e.scancode = USAGE_CODE[u[6:0]];
			e.extended = ((u >= 8'h49) && (u <= 8'h52)) || (u == 8'h54) ||
			             (u == 8'h58) || (u == 8'h65);
		end
		return e;
	endfunction

endpackage

/* design/hkse_lane.sv */
// ----------------------------------------------------------------------------
// hkse_lane
// One key slot: decides whether the previous usage of the slot is released
// and whether the new usage of the slot is pressed.
// ----------------------------------------------------------------------------
module hkse_lane #(
	parameter int NSLOT = 6
) (
	input  logic                  cmd,
	input  logic [7:0]            prev_key,
	input  logic [7:0]            new_key,
	input  logic [NSLOT-1:0][7:0] prev_set,
	input  logic [NSLOT-1:0][7:0] new_set,
	output logic                  rel,
	output logic                  prs
);
	import hkse_pkg::*;

	logic prev_in_new;
	logic new_in_prev;

	// Membership of this slot's usages in the other report
	always_comb begin
		prev_in_new = 1'b0;
		new_in_prev = 1'b0;
		for (int j = 0; j < NSLOT; j++) begin
			if (new_set[j] == prev_key) prev_in_new = 1'b1;
			if (prev_set[j] == new_key) new_in_prev = 1'b1;
		end
	end

	// Release-all frees every held usage; a report only the missing ones
	always_comb begin
		if (cmd == CMD_RELEASE) begin
			rel = usage_mapped(prev_key);
			prs = 1'b0;
		end else begin
			rel = usage_mapped(prev_key) && !prev_in_new;
			prs = usage_mapped(new_key) && !new_in_prev;
		end
	end

endmodule

/* design/hkse_merge.sv */
// ----------------------------------------------------------------------------
// hkse_merge
// Picks the next pending event in output order (modifier changes, key
// releases, key presses, modifier releases, completion) and formats it.
// ----------------------------------------------------------------------------
module hkse_merge #(
	parameter int NSLOT = 6
) (
	input  logic [7:0]            pre,
	input  logic [NSLOT-1:0]      rel,
	input  logic [NSLOT-1:0]      prs,
	input  logic [7:0]            post,
	input  logic [7:0]            mod_val,
	input  logic [NSLOT-1:0][7:0] old_keys,
	input  logic [NSLOT-1:0][7:0] new_keys,
	input  logic                  status,
	output hkse_pkg::evt_item_t   evt,
	output logic                  done,
	output logic [7:0]            pre_nxt,
	output logic [NSLOT-1:0]      rel_nxt,
	output logic [NSLOT-1:0]      prs_nxt,
	output logic [7:0]            post_nxt
);
	import hkse_pkg::*;

	localparam logic [NSLOT-1:0] ONE_N = NSLOT'(1);

	logic [7:0]       sel_pre;
	logic [7:0]       sel_post;
	logic [7:0]       sel_mod;
	logic [NSLOT-1:0] sel_rel;
	logic [NSLOT-1:0] sel_prs;
	logic [7:0]       usage_rel;
	logic [7:0]       usage_prs;
	logic [7:0]       mod_sc;
	evt_item_t        mod_evt;

	// Lowest pending bit of each group
	assign sel_pre  = pre & (~pre + 8'd1);
	assign sel_post = post & (~post + 8'd1);
	assign sel_rel  = rel & (~rel + ONE_N);
	assign sel_prs  = prs & (~prs + ONE_N);
	assign sel_mod  = (pre != 8'd0) ? sel_pre : sel_post;

	// One-hot selects into usages and modifier codes
	always_comb begin
		usage_rel = 8'd0;
		usage_prs = 8'd0;
		mod_sc    = 8'd0;
		for (int i = 0; i < NSLOT; i++) begin
			if (sel_rel[i]) usage_rel = usage_rel | old_keys[i];
			if (sel_prs[i]) usage_prs = usage_prs | new_keys[i];
		end
		for (int i = 0; i < 8; i++) begin
			if (sel_mod[i]) mod_sc = mod_sc | MOD_CODE[i];
		end
	end

	always_comb begin
		mod_evt          = '0;
		mod_evt.kind     = KIND_KEY;
		mod_evt.scancode = mod_sc;
		mod_evt.extended = |(sel_mod & MOD_EXT);
		mod_evt.pressed  = |(sel_pre & mod_val);
	end

	// Priority across groups, clearing the bit that goes out
	always_comb begin
		evt      = '0;
		done     = 1'b0;
		pre_nxt  = pre;
		rel_nxt  = rel;
		prs_nxt  = prs;
		post_nxt = post;
		if (pre != 8'd0) begin
			evt     = mod_evt;
			pre_nxt = pre & ~sel_pre;
		end else if (rel != '0) begin
			evt     = usage_event(usage_rel, 1'b0);
			rel_nxt = rel & ~sel_rel;
		end else if (prs != '0) begin
			evt     = usage_event(usage_prs, 1'b1);
			prs_nxt = prs & ~sel_prs;
		end else if (post != 8'd0) begin
			evt      = mod_evt;
			post_nxt = post & ~sel_post;
		end else begin
			evt.kind   = KIND_DONE;
			evt.status = status;
			evt.last   = 1'b1;
			done       = 1'b1;
		end
	end

endmodule

/* design/hid_keyboard_report_to_scancode_events.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_scancode_events
// Turns HID boot keyboard reports into Set1 make/break key events.
// ----------------------------------------------------------------------------
// Usage:
//   rpt channel (valid/ready) takes one report or release-all command.
//   evt channel (valid/ready) returns the key events the item causes,
//   followed by one completion item with last set and the status.
//   One item is in work at a time: rpt_ready is high only while idle.
//   Order: the item is accepted in the idle state, then in the load state
//   the slot lanes evaluate all slots at once, then the merge stage gives
//   one result per cycle while evt_ready does not stall it. An item with n
//   events gives n + 1 results, 21 at the worst case.
//   The result register lets the next item be accepted while the
//   completion of the previous one still waits on evt_ready; a stalled
//   receiver holds the sequencer in place with no result lost.
//   Reset clears the stored modifiers and key slots, so the first report
//   is compared against an empty keyboard.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_scancode_events #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rpt_valid,
	output logic                rpt_ready,
	input  hkse_pkg::rpt_item_t rpt,
	output logic                evt_valid,
	input  logic                evt_ready,
	output hkse_pkg::evt_item_t evt
);
	import hkse_pkg::*;

	localparam int NSLOT = (KEY_SLOTS < MAX_SLOTS) ? KEY_SLOTS : MAX_SLOTS;

	state_t state_q, state_nxt;

	rpt_item_t             in_s1;
	logic [MAX_SLOTS-1:0][7:0] keys_all;
	logic [NSLOT-1:0][7:0] new_keys;
	logic [NSLOT-1:0][7:0] prev_keys_q;
	logic [NSLOT-1:0][7:0] old_keys_q;
	logic [7:0]            prev_mods_q;

	logic [7:0]       pre_q, post_q, mod_val_q;
	logic [NSLOT-1:0] rel_q, prs_q;
	logic             status_q;

	logic [NSLOT-1:0] lane_rel, lane_prs;
	logic             reject;

	evt_item_t        m_evt;
	logic             m_done;
	logic [7:0]       pre_nxt, post_nxt;
	logic [NSLOT-1:0] rel_nxt, prs_nxt;

	evt_item_t evt_q;
	logic      evt_valid_q;
	logic      load_go, emit_go, rpt_take;

	// New key slots of the item in work
	assign keys_all = {in_s1.key_5, in_s1.key_4, in_s1.key_3,
	                   in_s1.key_2, in_s1.key_1, in_s1.key_0};

	for (genvar i = 0; i < NSLOT; i++) begin : g_keys
		assign new_keys[i] = keys_all[i];
	end

	// Slot lanes
	for (genvar i = 0; i < NSLOT; i++) begin : g_lane
		hkse_lane #(.NSLOT(NSLOT)) u_lane (
			.cmd      (in_s1.cmd),
			.prev_key (prev_keys_q[i]),
			.new_key  (new_keys[i]),
			.prev_set (prev_keys_q),
			.new_set  (new_keys),
			.rel      (lane_rel[i]),
			.prs      (lane_prs[i])
		);
	end

	assign reject = (in_s1.cmd == CMD_REPORT) && (in_s1.reserved_byte != 8'd0);

	// Event selection
	hkse_merge #(.NSLOT(NSLOT)) u_merge (
		.pre      (pre_q),
		.rel      (rel_q),
		.prs      (prs_q),
		.post     (post_q),
		.mod_val  (mod_val_q),
		.old_keys (old_keys_q),
		.new_keys (new_keys),
		.status   (status_q),
		.evt      (m_evt),
		.done     (m_done),
		.pre_nxt  (pre_nxt),
		.rel_nxt  (rel_nxt),
		.prs_nxt  (prs_nxt),
		.post_nxt (post_nxt)
	);

	// Sequencer next state and strobes
	always_comb begin
		state_nxt = state_q;
		rpt_ready = 1'b0;
		load_go   = 1'b0;
		emit_go   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rpt_ready = 1'b1;
				if (rpt_valid) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				load_go   = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				emit_go = !evt_valid_q || evt_ready;
				if (emit_go && m_done) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign rpt_take = rpt_valid && rpt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (rpt_take) begin
			in_s1 <= rpt;
		end
	end

	// Stored report and pending event masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= 8'd0;
			prev_keys_q <= '0;
			pre_q       <= 8'd0;
			post_q      <= 8'd0;
			mod_val_q   <= 8'd0;
			rel_q       <= '0;
			prs_q       <= '0;
			status_q    <= STATUS_OK;
		end else if (load_go) begin
			status_q <= reject ? STATUS_BAD : STATUS_OK;
			rel_q    <= reject ? '0 : lane_rel;
			prs_q    <= reject ? '0 : lane_prs;
			if (in_s1.cmd == CMD_RELEASE) begin
				pre_q       <= 8'd0;
				post_q      <= prev_mods_q;
				mod_val_q   <= 8'd0;
				prev_mods_q <= 8'd0;
				prev_keys_q <= '0;
			end else if (reject) begin
				pre_q  <= 8'd0;
				post_q <= 8'd0;
			end else begin
				pre_q       <= in_s1.modifiers ^ prev_mods_q;
				post_q      <= 8'd0;
				mod_val_q   <= in_s1.modifiers;
				prev_mods_q <= in_s1.modifiers;
				prev_keys_q <= new_keys;
			end
		end else if (emit_go) begin
			pre_q  <= pre_nxt;
			rel_q  <= rel_nxt;
			prs_q  <= prs_nxt;
			post_q <= post_nxt;
		end
	end

	// Copy of the previous slots for the release pass
	always_ff @(posedge clk) begin
		if (load_go) begin
			old_keys_q <= prev_keys_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (emit_go) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			evt_q <= m_evt;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

endmodule

/* design/hkse_checker.sv */
// ----------------------------------------------------------------------------
// hkse_checker
// Port-level checks for the scancode event translator, bound to the top.
// ----------------------------------------------------------------------------
module hkse_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rpt_valid,
	input logic                rpt_ready,
	input logic                evt_valid,
	input logic                evt_ready,
	input hkse_pkg::evt_item_t evt
);
	import hkse_pkg::*;

	// A stalled result holds
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt))
		else $error("result changed while stalled");

	// One item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt_ready |=> !rpt_ready)
		else $error("second item taken while busy");

	// Only the completion item is marked last
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (evt.last == (evt.kind == KIND_DONE)))
		else $error("last flag does not match item kind");

	// Key events carry no status
	a_key_status: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt.kind == KIND_KEY) |-> (evt.status == STATUS_OK))
		else $error("status set on a key event");

	// Virtual-key events carry only the two known codes and no scancode
	a_vk_code: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.use_vk |->
			((evt.vk_code == VK_PRTSC) || (evt.vk_code == VK_BREAK)) &&
			(evt.scancode == 8'd0) && !evt.extended)
		else $error("malformed virtual-key event");

endmodule

bind hid_keyboard_report_to_scancode_events hkse_checker u_hkse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rpt_valid (rpt_valid),
	.rpt_ready (rpt_ready),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.evt       (evt)
);

/* tb/tb_hid_keyboard_report_to_scancode_events.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_to_scancode_events
// Self-checking bench for the report to scancode event translator. A
// scoreboard tracks the held modifiers and key slots, builds the expected
// make/break events and completion for every accepted report, and checks
// each result item in order. Directed reports cover the extremes, then
// random report sequences run with random idling on both channels and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_to_scancode_events;
	import hkse_pkg::*;

	localparam int SLOT_COUNT     = 6;
	localparam int RANDOM_ITEMS   = 350;
	localparam int CALM_ITEMS     = 60;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int REPORTED_MAX   = 10;

	// Usage decoding, kept independent of the design
	localparam logic [7:0] FIRST_MAPPED     = 8'h04;
	localparam logic [7:0] MAP_END          = 8'h66;
	localparam logic [7:0] KEY_PRINT_SCREEN = 8'h46;
	localparam logic [7:0] KEY_PAUSE        = 8'h48;
	localparam logic [7:0] VK_PRINT_SCREEN  = 8'h2C;
	localparam logic [7:0] VK_BREAK_CODE    = 8'h13;

	localparam logic [7:0] MOD_MAKE [8] = '{
		8'h1D, 8'h2A, 8'h38, 8'h5B, 8'h1D, 8'h36, 8'h38, 8'h5C
	};
	// E0 prefix on RCtrl, RAlt and both GUI keys
	localparam logic [7:0] MOD_E0 = 8'b1101_1000;

	localparam logic [7:0] SET1_MAKE [102] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
		8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
		8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
		8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
		8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
		8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
		8'h1B, 8'h2B, 8'h56, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
		8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
		8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00, 8'h46,
		8'h00, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D,
		8'h4B, 8'h50, 8'h48, 8'h45, 8'h35, 8'h37, 8'h4A, 8'h4E,
		8'h1C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47,
		8'h48, 8'h49, 8'h52, 8'h53, 8'h56, 8'h5D
	};

	// Keyboard state tracker and expected event store
	class scancode_scoreboard;
		logic [7:0] held_mods;
		logic [7:0] held_keys [SLOT_COUNT];
		evt_item_t  pending_events [$];
		int         mismatches;

		function new();
			held_mods  = '0;
			foreach (held_keys[i]) held_keys[i] = '0;
			mismatches = 0;
		endfunction

		function bit holds(input logic [7:0] slots [SLOT_COUNT], input logic [7:0] k);
			foreach (slots[j]) if (slots[j] == k) return 1'b1;
			return 1'b0;
		endfunction

		function void push_modifier(input int bit_idx, input logic down);
			evt_item_t e;
			e          = '0;
			e.kind     = KIND_KEY;
			e.scancode = MOD_MAKE[bit_idx];
			e.extended = MOD_E0[bit_idx];
			e.pressed  = down;
			pending_events.push_back(e);
		endfunction

		function void push_usage(input logic [7:0] u, input logic down);
			evt_item_t e;
			if (u < FIRST_MAPPED || u >= MAP_END) return;
			e         = '0;
			e.kind    = KIND_KEY;
			e.pressed = down;
			if (u == KEY_PRINT_SCREEN) begin
				e.use_vk  = 1'b1;
				e.vk_code = VK_PRINT_SCREEN;
			end else if (u == KEY_PAUSE) begin
				e.use_vk  = 1'b1;
				e.vk_code = VK_BREAK_CODE;
			end else begin
				e.scancode = SET1_MAKE[u];
				e.extended = (u >= 8'h49 && u <= 8'h52) || u == 8'h54 ||
				             u == 8'h58 || u == 8'h65;
			end
			pending_events.push_back(e);
		endfunction

		// Expected events and completion of one accepted input item
		function void note_report(input rpt_item_t r);
			logic [7:0] now_keys [SLOT_COUNT];
			logic [7:0] diff;
			evt_item_t  done;
			now_keys = '{r.key_0, r.key_1, r.key_2, r.key_3, r.key_4, r.key_5};
			done        = '0;
			done.kind   = KIND_DONE;
			done.last   = 1'b1;
			done.status = STATUS_OK;
			if (r.cmd == CMD_RELEASE) begin
				// keys first, then modifiers, then forget everything
				foreach (held_keys[i]) if (held_keys[i] != 0) push_usage(held_keys[i], 1'b0);
				for (int i = 0; i < 8; i++) if (held_mods[i]) push_modifier(i, 1'b0);
				held_mods = '0;
				foreach (held_keys[i]) held_keys[i] = '0;
			end else if (r.reserved_byte != 0) begin
				done.status = STATUS_BAD;
			end else begin
				diff = r.modifiers ^ held_mods;
				for (int i = 0; i < 8; i++) if (diff[i]) push_modifier(i, r.modifiers[i]);
				foreach (held_keys[i])
					if (held_keys[i] != 0 && !holds(now_keys, held_keys[i]))
						push_usage(held_keys[i], 1'b0);
				foreach (now_keys[i])
					if (now_keys[i] != 0 && !holds(held_keys, now_keys[i]))
						push_usage(now_keys[i], 1'b1);
				held_mods = r.modifiers;
				held_keys = now_keys;
			end
			pending_events.push_back(done);
		endfunction

		// Compare one accepted result item with the oldest expectation
		function void check_event(input evt_item_t got);
			evt_item_t exp;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORTED_MAX)
					$display("%0t unexpected result item: kind=%0d sc=%02h ext=%0d vk=%0d/%02h dn=%0d st=%0d last=%0d",
					         $time, got.kind, got.scancode, got.extended, got.use_vk,
					         got.vk_code, got.pressed, got.status, got.last);
				return;
			end
			exp = pending_events.pop_front();
			if (got.kind !== exp.kind || got.scancode !== exp.scancode ||
			    got.extended !== exp.extended || got.use_vk !== exp.use_vk ||
			    got.vk_code !== exp.vk_code || got.pressed !== exp.pressed ||
			    got.status !== exp.status || got.last !== exp.last) begin
				mismatches++;
				if (mismatches <= REPORTED_MAX) begin
					$display("%0t result mismatch:", $time);
					$display("  exp kind=%0d sc=%02h ext=%0d vk=%0d/%02h dn=%0d st=%0d last=%0d",
					         exp.kind, exp.scancode, exp.extended, exp.use_vk,
					         exp.vk_code, exp.pressed, exp.status, exp.last);
					$display("  got kind=%0d sc=%02h ext=%0d vk=%0d/%02h dn=%0d st=%0d last=%0d",
					         got.kind, got.scancode, got.extended, got.use_vk,
					         got.vk_code, got.pressed, got.status, got.last);
				end
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      rpt_valid;
	logic      rpt_ready;
	rpt_item_t rpt;
	logic      evt_valid;
	logic      evt_ready;
	evt_item_t evt;

	scancode_scoreboard board = new();
	bit idle_on      = 1'b1;
	bit hold_request = 1'b0;

	hid_keyboard_report_to_scancode_events DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt       (rpt),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rpt_item_t make_report(input logic c, input logic [7:0] mods,
		input logic [7:0] rsv, input logic [7:0] k0, input logic [7:0] k1,
		input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4,
		input logic [7:0] k5);
		rpt_item_t r;
		r = '{c, mods, rsv, k0, k1, k2, k3, k4, k5};
		return r;
	endfunction

	// Mostly mapped usages, with empty slots and unmapped ids mixed in
	function automatic logic [7:0] pick_usage();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'h00;
		if (r < 14) return 8'($urandom_range(0, 255));
		if (r < 17) return 8'($urandom_range(1, 3));
		if (r < 20) return 8'($urandom_range(8'h66, 8'hFF));
		return 8'($urandom_range(FIRST_MAPPED, 8'h65));
	endfunction

	// Offer one input item and wait for it to be taken
	task automatic offer_report(input rpt_item_t item);
		rpt       <= item;
		rpt_valid <= 1'b1;
		do @(posedge clk); while (!rpt_ready);
		board.note_report(item);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			rpt_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Result side: check accepted items, random stalls, one long hold-off
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		evt_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (evt_valid && evt_ready) board.check_event(evt);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				evt_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				evt_ready <= 1'b0;
			end else begin
				evt_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no item moving on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rpt_valid && rpt_ready) || (evt_valid && evt_ready)) quiet = 0;
			else quiet++;
		end
		$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_hid_keyboard_report_to_scancode_events: FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] gen_mods;
		logic [7:0] gen_keys [SLOT_COUNT];
		rpt_item_t  item;
		int         pick;

		arst_n    <= 1'b0;
		rpt_valid <= 1'b0;
		rpt       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty board, all modifiers, full key turnover
		offer_report(make_report(CMD_REPORT, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
		offer_report(make_report(CMD_REPORT, 8'hFF, 8'h00, 8'h04, 8'h05, 8'h06,
		                         8'h07, 8'h08, 8'h09));
		// all eight modifiers drop, six keys out, six in: the longest item
		offer_report(make_report(CMD_REPORT, 8'h00, 8'h00, 8'h0A, 8'h0B, 8'h0C,
		                         8'h0D, 8'h0E, 8'h0F));
		// virtual-key usages and the E0 navigation block
		offer_report(make_report(CMD_REPORT, 8'hAA, 8'h00, KEY_PRINT_SCREEN, KEY_PAUSE,
		                         8'h49, 8'h52, 8'h54, 8'h58));
		// last mapped usage next to unmapped ones, still stored as held
		offer_report(make_report(CMD_REPORT, 8'h55, 8'h00, 8'h65, 8'h66, 8'hFF,
		                         8'h00, 8'h01, 8'h03));
		// rejected reports leave the board untouched
		offer_report(make_report(CMD_REPORT, 8'h0F, 8'hFF, 8'h04, 8'h05, 8'h06,
		                         8'h07, 8'h08, 8'h09));
		offer_report(make_report(CMD_REPORT, 8'hF0, 8'h01, 8'hFF, 8'hFF, 8'hFF,
		                         8'hFF, 8'hFF, 8'hFF));
		// duplicates in both the old and the new report
		offer_report(make_report(CMD_REPORT, 8'h55, 8'h00, 8'h04, 8'h04, 8'h66,
		                         8'h04, 8'h02, 8'h39));
		offer_report(make_report(CMD_REPORT, 8'h55, 8'h00, 8'h04, 8'h04, 8'h66,
		                         8'h04, 8'h02, 8'h39));
		offer_report(make_report(CMD_REPORT, 8'h80, 8'h00, 8'h39, 8'h53, 8'h47,
		                         8'h50, 8'h62, 8'h64));
		// release all ignores every other field
		offer_report(make_report(CMD_RELEASE, 8'h5A, 8'hC3, 8'h11, 8'h22, 8'h33,
		                         8'h44, 8'h55, 8'h66));
		offer_report(make_report(CMD_RELEASE, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
		offer_report(make_report(CMD_REPORT, 8'h01, 8'h00, 8'h80, 8'h7F, 8'hAA,
		                         8'h55, 8'hFE, 8'h02));
		offer_report(make_report(CMD_REPORT, 8'h01, 8'h80, 8'h2C, 8'h28, 8'h29,
		                         8'h2A, 8'h2B, 8'h63));
		offer_report(make_report(CMD_REPORT, 8'hFE, 8'h00, 8'h2C, 8'h28, 8'h29,
		                         8'h2A, 8'h2B, 8'h63));
		offer_report(make_report(CMD_RELEASE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		                         8'hFF, 8'hFF, 8'hFF));

		// Random report sequences; keys often stay held or move slot
		gen_mods = '0;
		foreach (gen_keys[i]) gen_keys[i] = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
			if (n == RANDOM_ITEMS / 2) hold_request = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				item = make_report(CMD_RELEASE, 8'($urandom), 8'($urandom), 8'($urandom),
				                   8'($urandom), 8'($urandom), 8'($urandom),
				                   8'($urandom), 8'($urandom));
				gen_mods = '0;
				foreach (gen_keys[i]) gen_keys[i] = '0;
			end else if (pick < 12) begin
				item = make_report(CMD_REPORT, 8'($urandom), 8'($urandom_range(1, 255)),
				                   pick_usage(), pick_usage(), pick_usage(),
				                   pick_usage(), pick_usage(), pick_usage());
			end else begin
				if ($urandom_range(0, 1) == 0) gen_mods = 8'($urandom);
				else gen_mods = gen_mods ^ (8'h01 << $urandom_range(0, 7));
				foreach (gen_keys[i]) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: ;
						4:          gen_keys[i] = gen_keys[$urandom_range(0, SLOT_COUNT - 1)];
						default:    gen_keys[i] = pick_usage();
					endcase
				end
				item = make_report(CMD_REPORT, gen_mods, 8'h00, gen_keys[0], gen_keys[1],
				                   gen_keys[2], gen_keys[3], gen_keys[4], gen_keys[5]);
			end
			offer_report(item);
		end
		rpt_valid <= 1'b0;

		// Drain and settle
		while (board.pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending_events.size() == 0) begin
			$display("tb_hid_keyboard_report_to_scancode_events: PASS");
		end else begin
			$display("mismatches: %0d, result items never seen: %0d",
			         board.mismatches, board.pending_events.size());
			$display("tb_hid_keyboard_report_to_scancode_events: FAIL");
		end
		$finish;
	end

endmodule
